### rtl/core/ilh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilh_pkg
// Shared types and constants of the interval latency histogram core.
// ----------------------------------------------------------------------------
package ilh_pkg;

  localparam int NUM_BUCKETS = 64;
  localparam int BKT_AW      = $clog2(NUM_BUCKETS);

  localparam logic [19:0] USEC_PER_SEC = 20'd1000000;
  localparam logic [19:0] USEC_MAX     = 20'd999999;

  // total duration in microseconds: 32-bit seconds times 1e6 plus micro part
  localparam int TOT_W = 52;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_SHIFT   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_BUCKETS = 1'd1;

  localparam logic [4:0] BUCKET_SHIFT_RST   = 5'd10;
  localparam logic [6:0] ACTIVE_BUCKETS_RST = 7'd64;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_END   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] start_seconds;
    logic [19:0] start_microseconds;
    logic [31:0] end_seconds;
    logic [19:0] end_microseconds;
    logic [5:0]  read_index;
  } in_t;

  typedef struct packed {
    logic [31:0] bucket_value;
    logic [31:0] calls_seen;
    logic [31:0] overflow_seen;
    logic [31:0] sum_seconds;
    logic [19:0] sum_microseconds;
  } out_t;

  // request bundle from the sequencer to the bucket memory
  typedef struct packed {
    logic              clr;
    logic              rd_en;
    logic [BKT_AW-1:0] rd_addr;
    logic              wr_en;
    logic [BKT_AW-1:0] wr_addr;
    logic [31:0]       wr_data;
  } mem_req_t;

endpackage

### rtl/core/ilh_bucket_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilh_bucket_mem
// Bucket count memory: one write and one registered read per cycle, with a
// valid bit per entry so that reset and clear take effect at once.
// ----------------------------------------------------------------------------
module ilh_bucket_mem (
  input  logic              clk,
  input  logic              rst_n,
  input  ilh_pkg::mem_req_t req,
  output logic [31:0]       rd_data
);

  logic [31:0]                      mem_r [ilh_pkg::NUM_BUCKETS];
  logic [ilh_pkg::NUM_BUCKETS-1:0] vld_r;
  logic [ilh_pkg::NUM_BUCKETS-1:0] vld_nxt;
  logic [31:0]                      rdata_r;
  logic                             rd_hit_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rdata_r <= mem_r[req.rd_addr];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (req.clr) begin
      vld_nxt = '0;
    end else if (req.wr_en) begin
      vld_nxt[req.wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_hit_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      if (req.rd_en) begin
        rd_hit_r <= vld_r[req.rd_addr];
      end
    end
  end

  // an entry never written since reset or clear reads as zero
  assign rd_data = rd_hit_r ? rdata_r : 32'd0;

endmodule

### rtl/core/interval_latency_histogram_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_latency_histogram_core
// Duration histogram: counts start events, bins end-event intervals into
// buckets of 2^bucket_shift microseconds and keeps overflow and time totals.
//
//   channel  direction  handshake              payload
//   in_      in         in_valid / in_ready    ilh_pkg::in_t
//   out_     out        out_valid / out_ready  ilh_pkg::out_t
//   cfg_     in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item at a time: start, clear and read pass through the bucket read and then
// the out register; an end event first passes through the difference, multiply,
// add, bin and bucket read-modify-write states.
// Reset and clear empty all buckets at once through per-entry valid bits.
// A new item is taken while the previous result waits in the out register;
// a stalled out side holds the next result in its final state.
// ----------------------------------------------------------------------------
module interval_latency_histogram_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  ilh_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output ilh_pkg::out_t                   out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ilh_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ilh_pkg::CFG_DATA_W-1:0]  cfg_data
);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_DIFF = 8'b0000_0010,
    ST_MUL  = 8'b0000_0100,
    ST_SUM  = 8'b0000_1000,
    ST_BIN  = 8'b0001_0000,
    ST_UPD  = 8'b0010_0000,
    ST_RD   = 8'b0100_0000,
    ST_RESP = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [4:0]  bucket_shift_r, bucket_shift_nxt;
  logic [6:0]  active_buckets_r, active_buckets_nxt;

  logic [31:0] call_r, call_nxt;
  logic [31:0] ovf_r, ovf_nxt;
  logic [31:0] sum_s_r, sum_s_nxt;
  logic [19:0] sum_us_r, sum_us_nxt;

  logic          out_valid_r, out_valid_nxt;
  ilh_pkg::out_t out_r, out_nxt;

  // datapath registers, no reset needed
  ilh_pkg::in_t                  in_r, in_nxt;
  logic [31:0]                   ds_r, ds_nxt;
  logic [19:0]                   du_r, du_nxt;
  logic                          late_r, late_nxt;
  logic [ilh_pkg::TOT_W-1:0]     prod_r, prod_nxt;
  logic [ilh_pkg::TOT_W-1:0]     tot_r, tot_nxt;
  logic                          hit_r, hit_nxt;
  logic [ilh_pkg::BKT_AW-1:0]    idx_r, idx_nxt;

  ilh_pkg::mem_req_t mem_req;
  logic [31:0]       mem_rdata;

  logic [19:0]               su_c, eu_c;
  logic                      borrow;
  logic [ilh_pkg::TOT_W-1:0] shifted;
  logic [ilh_pkg::TOT_W-1:0] limit;
  logic [20:0]               us_sum;
  logic                      us_carry;

  ilh_bucket_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .rd_data (mem_rdata)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // interval difference with microsecond borrow, inputs saturated first
  always_comb begin
    su_c   = (in_r.start_microseconds > ilh_pkg::USEC_MAX) ? ilh_pkg::USEC_MAX
                                                           : in_r.start_microseconds;
    eu_c   = (in_r.end_microseconds > ilh_pkg::USEC_MAX) ? ilh_pkg::USEC_MAX
                                                         : in_r.end_microseconds;
    borrow = (eu_c < su_c);
  end

  always_comb begin
    shifted = tot_r >> bucket_shift_r;
    if (ilh_pkg::TOT_W'(active_buckets_r) > ilh_pkg::TOT_W'(ilh_pkg::NUM_BUCKETS)) begin
      limit = ilh_pkg::TOT_W'(ilh_pkg::NUM_BUCKETS);
    end else begin
      limit = ilh_pkg::TOT_W'(active_buckets_r);
    end
  end

  always_comb begin
    us_sum   = {1'b0, sum_us_r} + {1'b0, du_r};
    us_carry = (us_sum >= {1'b0, ilh_pkg::USEC_PER_SEC});
  end

  always_comb begin
    state_nxt          = state_r;
    bucket_shift_nxt   = bucket_shift_r;
    active_buckets_nxt = active_buckets_r;
    call_nxt           = call_r;
    ovf_nxt            = ovf_r;
    sum_s_nxt          = sum_s_r;
    sum_us_nxt         = sum_us_r;
    out_valid_nxt      = out_valid_r;
    out_nxt            = out_r;
    in_nxt             = in_r;
    ds_nxt             = ds_r;
    du_nxt             = du_r;
    late_nxt           = late_r;
    prod_nxt           = prod_r;
    tot_nxt            = tot_r;
    hit_nxt            = hit_r;
    idx_nxt            = idx_r;
    mem_req            = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ilh_pkg::CFG_BUCKET_SHIFT:   bucket_shift_nxt   = cfg_data[4:0];
        ilh_pkg::CFG_ACTIVE_BUCKETS: active_buckets_nxt = cfg_data[6:0];
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          in_nxt = in_data;
          case (in_data.op)
            ilh_pkg::OP_START: begin
              call_nxt  = call_r + 32'd1;
              state_nxt = ST_RD;
            end
            ilh_pkg::OP_CLEAR: begin
              call_nxt    = '0;
              ovf_nxt     = '0;
              sum_s_nxt   = '0;
              sum_us_nxt  = '0;
              mem_req.clr = 1'b1;
              state_nxt   = ST_RD;
            end
            ilh_pkg::OP_END: state_nxt = ST_DIFF;
            default:         state_nxt = ST_RD;
          endcase
        end
      end
      ST_DIFF: begin
        late_nxt = (in_r.end_seconds < in_r.start_seconds) ||
                   ((in_r.end_seconds == in_r.start_seconds) && borrow);
        ds_nxt   = in_r.end_seconds - in_r.start_seconds - {31'd0, borrow};
        if (borrow) begin
          du_nxt = 20'({1'b0, eu_c} + {1'b0, ilh_pkg::USEC_PER_SEC} - {1'b0, su_c});
        end else begin
          du_nxt = eu_c - su_c;
        end
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        prod_nxt  = ilh_pkg::TOT_W'(ds_r) * ilh_pkg::TOT_W'(ilh_pkg::USEC_PER_SEC);
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        tot_nxt   = prod_r + ilh_pkg::TOT_W'(du_r);
        state_nxt = ST_BIN;
      end
      ST_BIN: begin
        hit_nxt         = !late_r && (shifted < limit);
        idx_nxt         = shifted[ilh_pkg::BKT_AW-1:0];
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = shifted[ilh_pkg::BKT_AW-1:0];
        state_nxt       = ST_UPD;
      end
      ST_UPD: begin
        // write lands before the result read issued in the next state
        if (hit_r) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = idx_r;
          mem_req.wr_data = mem_rdata + 32'd1;
        end else begin
          ovf_nxt = ovf_r + 32'd1;
        end
        if (!late_r) begin
          sum_us_nxt = us_carry ? 20'(us_sum - {1'b0, ilh_pkg::USEC_PER_SEC})
                                : us_sum[19:0];
          sum_s_nxt  = sum_s_r + ds_r + {31'd0, us_carry};
        end
        state_nxt = ST_RD;
      end
      ST_RD: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = ilh_pkg::BKT_AW'(in_r.read_index);
        state_nxt       = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.bucket_value     = mem_rdata;
          out_nxt.calls_seen       = call_r;
          out_nxt.overflow_seen    = ovf_r;
          out_nxt.sum_seconds      = sum_s_r;
          out_nxt.sum_microseconds = sum_us_r;
          out_valid_nxt            = 1'b1;
          state_nxt                = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      bucket_shift_r   <= ilh_pkg::BUCKET_SHIFT_RST;
      active_buckets_r <= ilh_pkg::ACTIVE_BUCKETS_RST;
      call_r           <= '0;
      ovf_r            <= '0;
      sum_s_r          <= '0;
      sum_us_r         <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r          <= state_nxt;
      bucket_shift_r   <= bucket_shift_nxt;
      active_buckets_r <= active_buckets_nxt;
      call_r           <= call_nxt;
      ovf_r            <= ovf_nxt;
      sum_s_r          <= sum_s_nxt;
      sum_us_r         <= sum_us_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    in_r   <= in_nxt;
    ds_r   <= ds_nxt;
    du_r   <= du_nxt;
    late_r <= late_nxt;
    prod_r <= prod_nxt;
    tot_r  <= tot_nxt;
    hit_r  <= hit_nxt;
    idx_r  <= idx_nxt;
  end

endmodule
